>>> hw/rtl/line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer RTL.
// Used by lr_core and lr_out; no other dependencies.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define LR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define LR_ASSERT(lbl, prop, msg) \
    `LR_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

>>> hw/rtl/lr_pkg.sv
// Shared constants, types and register codes of the line rasterizer.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package lr_pkg;

    localparam int COORD_BITS = 13;
    localparam int DIM_BITS   = 13;
    localparam int COLOR_BITS = 24;

    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Cross-product error: products of two coordinate differences plus margin.
    localparam int ERR_BITS = 2 * COORD_BITS + 5;
    localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic KIND_BEGIN   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET = DIM_BITS'(480);

    typedef struct packed {
        logic [DIM_BITS-1:0] image_width;
        logic [DIM_BITS-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] pixel_color;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COORD_BITS-1:0] pixel_x;
        logic                  write_enable;
        logic                  last;
    } result_t;

endpackage

>>> hw/rtl/lr_regs.sv
// APB register file of the line rasterizer: image width and height.
// Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lr_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output lr_pkg::cfg_t                  cfg
);

    logic         reg_sel;
    logic         wr_en;
    lr_pkg::cfg_t cfg_reg;

    assign reg_sel = paddr[lr_pkg::APB_ADDR_W-1];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= lr_pkg::IMAGE_WIDTH_RESET;
            cfg_reg.image_height <= lr_pkg::IMAGE_HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                lr_pkg::REG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= pwdata[lr_pkg::DIM_BITS-1:0];
                end
                lr_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_reg.image_height <= pwdata[lr_pkg::DIM_BITS-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            lr_pkg::REG_IMAGE_WIDTH:  prdata = lr_pkg::APB_DATA_W'(cfg_reg.image_width);
            lr_pkg::REG_IMAGE_HEIGHT: prdata = lr_pkg::APB_DATA_W'(cfg_reg.image_height);
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/lr_core.sv
// Input register, line state and one-step cross-product walker.
// Depends on lr_pkg and line_rasterizer_macros.svh.
`timescale 1ns / 1ps
`include "line_rasterizer_macros.svh"

module lr_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lr_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  lr_pkg::cfg_t                 cfg,
    input  logic                         out_ready,
    output logic                         res_valid,
    output lr_pkg::result_t              res
);

    localparam int C = lr_pkg::COORD_BITS;
    localparam int E = lr_pkg::ERR_BITS;

    localparam logic [C-1:0] COORD_MAX = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] COORD_MIN = {1'b1, {(C-1){1'b0}}};

    // Input register
    logic                         in_valid_reg;
    logic                         in_kind_reg;
    logic [lr_pkg::IN_DATA_W-1:0] in_data_reg;

    // Line state
    logic                           active_reg;
    logic [C-1:0]                   cur_x_reg;
    logic [C-1:0]                   cur_y_reg;
    logic [C-1:0]                   target_x_reg;
    logic [C-1:0]                   target_y_reg;
    logic [lr_pkg::COLOR_BITS-1:0]  color_reg;
    logic                           x_pos_reg;
    logic                           y_pos_reg;
    logic signed [C:0]              ddx_reg;
    logic signed [C:0]              ddy_reg;
    logic signed [E-1:0]            err_reg;

    logic                          in_take;
    logic                          proc_fire;
    logic [C-1:0]                  start_x;
    logic [C-1:0]                  start_y;
    logic [C-1:0]                  end_x;
    logic [C-1:0]                  end_y;
    logic [lr_pkg::COLOR_BITS-1:0] in_color;
    logic signed [C:0]             ddx_new;
    logic signed [C:0]             ddy_new;
    logic                          begin_nonempty;

    logic signed [E-1:0] ddx_ext;
    logic signed [E-1:0] ddy_ext;
    logic signed [E-1:0] dx_step;
    logic signed [E-1:0] dy_step;
    logic signed [E-1:0] ex_v;
    logic signed [E-1:0] ey_v;
    logic signed [E-1:0] ex_abs;
    logic signed [E-1:0] ey_abs;
    logic signed [E-1:0] err_x;
    logic signed [E-1:0] err_y;
    logic                take_x;
    logic                wrap_x;
    logic                wrap_y;
    logic [C-1:0]        x_inc;
    logic [C-1:0]        y_inc;
    logic [C-1:0]        cur_x_next;
    logic [C-1:0]        cur_y_next;
    logic signed [E-1:0] err_next;
    logic                in_image;
    logic                last_hit;

    assign s_tready  = !in_valid_reg || out_ready;
    assign in_take   = s_tvalid && s_tready;
    assign proc_fire = in_valid_reg && out_ready;

    assign start_x  = in_data_reg[C-1:0];
    assign start_y  = in_data_reg[2*C-1:C];
    assign end_x    = in_data_reg[3*C-1:2*C];
    assign end_y    = in_data_reg[4*C-1:3*C];
    assign in_color = in_data_reg[4*C+lr_pkg::COLOR_BITS-1:4*C];

    assign ddx_new = $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
    assign ddy_new = $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});
    assign begin_nonempty = (start_x != end_x) || (start_y != end_y);

    // Error e = (x - x0) * dy - (y - y0) * dx, kept incrementally.
    assign ddx_ext = E'(ddx_reg);
    assign ddy_ext = E'(ddy_reg);
    assign dx_step = x_pos_reg ? ddy_ext : -ddy_ext;
    assign dy_step = y_pos_reg ? -ddx_ext : ddx_ext;
    assign ex_v    = err_reg + dx_step;
    assign ey_v    = err_reg + dy_step;
    assign ex_abs  = ex_v[E-1] ? -ex_v : ex_v;
    assign ey_abs  = ey_v[E-1] ? -ey_v : ey_v;
    assign take_x  = ex_abs < ey_abs;

    assign x_inc  = x_pos_reg ? cur_x_reg + C'(1) : cur_x_reg - C'(1);
    assign y_inc  = y_pos_reg ? cur_y_reg + C'(1) : cur_y_reg - C'(1);
    assign wrap_x = x_pos_reg ? (cur_x_reg == COORD_MAX) : (cur_x_reg == COORD_MIN);
    assign wrap_y = y_pos_reg ? (cur_y_reg == COORD_MAX) : (cur_y_reg == COORD_MIN);

    // A wrapped coordinate moves by a full 2^C span; fold that into the error.
    assign err_x = ex_v - (wrap_x ? (dx_step <<< C) : '0);
    assign err_y = ey_v - (wrap_y ? (dy_step <<< C) : '0);

    assign cur_x_next = take_x ? x_inc : cur_x_reg;
    assign cur_y_next = take_x ? cur_y_reg : y_inc;
    assign err_next   = take_x ? err_x : err_y;
    assign last_hit   = (cur_x_next == target_x_reg) && (cur_y_next == target_y_reg);

    assign in_image = !cur_x_reg[C-1] && !cur_y_reg[C-1] &&
                      (lr_pkg::CMP_BITS'(cur_x_reg) < lr_pkg::CMP_BITS'(cfg.image_width)) &&
                      (lr_pkg::CMP_BITS'(cur_y_reg) < lr_pkg::CMP_BITS'(cfg.image_height));

    assign res_valid        = proc_fire && (in_kind_reg == lr_pkg::KIND_ADVANCE) && active_reg;
    assign res.pixel_x      = cur_x_reg;
    assign res.pixel_y      = cur_y_reg;
    assign res.pixel_color  = color_reg;
    assign res.write_enable = in_image;
    assign res.last         = last_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (proc_fire) begin
            if (in_kind_reg == lr_pkg::KIND_BEGIN) begin
                active_reg <= begin_nonempty;
            end else if (active_reg && last_hit) begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            if (in_kind_reg == lr_pkg::KIND_BEGIN) begin
                cur_x_reg    <= start_x;
                cur_y_reg    <= start_y;
                target_x_reg <= end_x;
                target_y_reg <= end_y;
                color_reg    <= in_color;
                x_pos_reg    <= $signed(end_x) > $signed(start_x);
                y_pos_reg    <= $signed(end_y) > $signed(start_y);
                ddx_reg      <= ddx_new;
                ddy_reg      <= ddy_new;
                err_reg      <= '0;
            end else if (active_reg) begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                err_reg   <= err_next;
            end
        end
    end

    `LR_ASSERT(a_last_clears_active, res_valid && res.last |=> !active_reg, "line still active after last pixel")
    `LR_ASSERT(a_empty_line_idle, proc_fire && (in_kind_reg == lr_pkg::KIND_BEGIN) && !begin_nonempty |=> !active_reg, "empty line left active")
    `LR_ASSERT(a_stalled_item_held, in_valid_reg && !out_ready |=> in_valid_reg, "stalled input item dropped")

endmodule

>>> hw/rtl/lr_out.sv
// Result register with skid stage for the line rasterizer master channel.
// Depends on lr_pkg and line_rasterizer_macros.svh.
`timescale 1ns / 1ps
`include "line_rasterizer_macros.svh"

module lr_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          res_valid,
    input  lr_pkg::result_t               res,
    output logic                          out_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic            main_valid_reg;
    logic            skid_valid_reg;
    lr_pkg::result_t main_reg;
    lr_pkg::result_t skid_reg;
    logic            pop;

    assign pop       = main_valid_reg && m_tready;
    assign out_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= res_valid;
            end else begin
                main_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            if (main_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                skid_reg <= res;
            end else begin
                main_reg <= res;
            end
        end else if (res_valid) begin
            if (main_valid_reg) begin
                skid_reg <= res;
            end else begin
                main_reg <= res;
            end
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = lr_pkg::OUT_DATA_W'({main_reg.pixel_color, main_reg.pixel_y,
                                           main_reg.pixel_x});
    assign m_tuser  = main_reg.write_enable;
    assign m_tlast  = main_reg.last;

    `LR_ASSERT(a_skid_behind_main, skid_valid_reg |-> main_valid_reg, "skid beat without main beat")
    `LR_ASSERT(a_no_push_when_full, res_valid |-> !skid_valid_reg, "result pushed into full output stage")
    `LR_ASSERT(a_skid_refills_main, pop && skid_valid_reg |=> main_valid_reg, "skid beat lost on pop")

endmodule

>>> hw/rtl/line_rasterizer.sv
// Path: an accepted advance beat passes the input register, then the result stage, to
// m_tvalid. Throughput: one beat per cycle unless the output stage is full; the line state
// advances one pixel per cycle through an incremental cross-product error register updated
// by adds and one magnitude compare.
// Reset (aresetn low, synchronous): no line active, both channels empty,
// image size back to 640 x 480.
`timescale 1ns / 1ps

module line_rasterizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata from bit 0: start_x, start_y, end_x, end_y, line_color, zero pad
    input  logic [lr_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: kind (0 begin line, 1 advance one pixel)
    input  logic                          s_tuser,
    // Result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata from bit 0: pixel_x, pixel_y, pixel_color, zero pad
    output logic [lr_pkg::OUT_DATA_W-1:0] m_tdata,
    // tuser: write_enable
    output logic                          m_tuser,
    output logic                          m_tlast,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lr_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    lr_pkg::cfg_t    cfg;
    lr_pkg::result_t res;
    logic            res_valid;
    logic            out_ready;

    // Image width at 0x0, image height at 0x4.
    lr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Register the input beat, then walk one pixel: clip against the image,
    // pick the x or y step with the smaller cross-product error, flag the end.
    lr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg),
        .out_ready (out_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold results in a two-deep output stage so the walker keeps going while
    // the downstream side stalls, until the skid register fills.
    lr_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> sim/line_rasterizer_test.sv
// Self-checking testbench for line_rasterizer: drives begin and advance beats,
// predicts every pixel write and checks it. Depends on lr_pkg and the block only.
`timescale 1ns / 1ps

module line_rasterizer_test;
    import lr_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One expected pixel write, in the order the block must emit them.
    typedef struct {
        coord_t                x;
        coord_t                y;
        logic [COLOR_BITS-1:0] rgb;
        logic                  we;
        logic                  last;
    } pixel_write_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // tdata from bit 0: start_x, start_y, end_x, end_y, line_color, zero pad
    logic [IN_DATA_W-1:0]  s_tdata;
    // tuser: kind (begin or advance)
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // tdata from bit 0: pixel_x, pixel_y, pixel_color, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    // tuser: write_enable
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    line_rasterizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Line state of the predictor, kept at the block's widths.
    coord_t                pen_x, pen_y;
    coord_t                line_x0, line_y0, line_x1, line_y1;
    logic [COLOR_BITS-1:0] line_rgb;
    bit                    line_live;
    logic [DIM_BITS-1:0]   img_w, img_h;

    pixel_write_t pending_writes[$];

    int err_count      = 0;
    int items_sent     = 0;   // beats that the block acts on
    int pixels_checked = 0;
    int lines_begun    = 0;
    int sizes_used     = 0;
    int rx_hold_cycles = 0;   // long output stall requested by a test
    bit quiet          = 1'b0; // no random idle cycles on either side while set

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("%0t: timeout, %0d pixel writes still expected", $time,
                 pending_writes.size());
        $display("line_rasterizer_test: errors");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Idle lengths: mostly none or short, a few long.
    // ---------------------------------------------------------------------
    function automatic int sender_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic int stall_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Receiver: random stalls, plus a long hold when a test asks for one.
    initial begin
        int n;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
                repeat (stall_len()) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Predictor: advance the line state by one accepted beat and queue the
    // pixel write it causes, if any.
    // ---------------------------------------------------------------------
    task automatic predict_beat(input logic kind, input coord_t x0, input coord_t y0,
                                input coord_t x1, input coord_t y1,
                                input logic [COLOR_BITS-1:0] rgb);
        longint cx, cy, ox, oy, tx, ty, stx, sty, ddx, ddy, err_x, err_y, w, h;
        pixel_write_t px;
        if (kind == KIND_BEGIN) begin
            line_x0 = x0;
            line_y0 = y0;
            line_x1 = x1;
            line_y1 = y1;
            line_rgb = rgb;
            pen_x = x0;
            pen_y = y0;
            // a zero-length line never goes live
            line_live = (x0 != x1) || (y0 != y1);
            lines_begun++;
        end else if (line_live) begin
            cx = pen_x;
            cy = pen_y;
            ox = line_x0;
            oy = line_y0;
            tx = line_x1;
            ty = line_y1;
            w = img_w;
            h = img_h;
            px.x = pen_x;
            px.y = pen_y;
            px.rgb = line_rgb;
            px.we = cx >= 0 && cy >= 0 && cx < w && cy < h;
            stx = (tx > ox) ? 1 : -1;
            sty = (ty > oy) ? 1 : -1;
            ddx = tx - ox;
            ddy = ty - oy;
            // distance from the ideal line after an x step and after a y step
            err_x = (cx + stx - ox) * ddy - (cy - oy) * ddx;
            err_y = (cx - ox) * ddy - (cy + sty - oy) * ddx;
            if (err_x < 0)
                err_x = -err_x;
            if (err_y < 0)
                err_y = -err_y;
            // a tie steps in y; the point wraps at the coordinate width
            if (err_x < err_y)
                pen_x = coord_t'(cx + stx);
            else
                pen_y = coord_t'(cy + sty);
            px.last = (pen_x == line_x1) && (pen_y == line_y1);
            if (px.last)
                line_live = 1'b0;
            pending_writes.push_back(px);
        end
    endtask

    // ---------------------------------------------------------------------
    // Sender: offer one beat, hold it until accepted, then predict it.
    // Called right after a rising edge; valid stays high into the next call
    // unless that call opens a gap.
    // ---------------------------------------------------------------------
    task automatic send_beat(input logic kind, input coord_t x0, input coord_t y0,
                             input coord_t x1, input coord_t y1,
                             input logic [COLOR_BITS-1:0] rgb);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_DATA_W - IN_FIELD_BITS){1'b0}}, rgb, y1, x1, y0, x0};
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (kind == KIND_BEGIN || line_live)
            items_sent++;
        predict_beat(kind, x0, y0, x1, y1, rgb);
    endtask

    // Advance with random filler in the unused fields.
    task automatic send_advance();
        send_beat(KIND_ADVANCE, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), COLOR_BITS'($urandom));
    endtask

    // Drop valid, let every expected write arrive, then cover the pipeline.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // Register access over APB.
    // ---------------------------------------------------------------------
    function automatic logic [APB_ADDR_W-1:0] reg_addr(input logic idx);
        return APB_ADDR_W'({idx, 2'b00});
    endfunction

    task automatic reg_write(input logic idx, input logic [DIM_BITS-1:0] val);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;   // upper bits are junk the block must drop
        word[DIM_BITS-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            img_w = val;
        else
            img_h = val;
        // leave the bus idle between transfers
        @(posedge aclk);
    endtask

    task automatic reg_check(input logic idx);
        logic [APB_DATA_W-1:0] want;
        want = {{(APB_DATA_W - DIM_BITS){1'b0}}, (idx == REG_IMAGE_WIDTH) ? img_w : img_h};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== want) begin
            err_count++;
            $display("%0t: register %0d read expected 0x%0h got 0x%0h", $time, idx, want,
                     prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_image_size(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
        wait_idle();
        reg_write(REG_IMAGE_WIDTH, w);
        reg_write(REG_IMAGE_HEIGHT, h);
        reg_check(REG_IMAGE_WIDTH);
        reg_check(REG_IMAGE_HEIGHT);
        sizes_used++;
    endtask

    // ---------------------------------------------------------------------
    // Pixel write checker.
    // ---------------------------------------------------------------------
    task automatic mismatch(input string field, input logic signed [31:0] want,
                            input logic signed [31:0] got);
        err_count++;
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin : check_pixels
        pixel_write_t          want;
        coord_t                got_x, got_y;
        logic [COLOR_BITS-1:0] got_rgb;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got_x   = m_tdata[COORD_BITS-1:0];
            got_y   = m_tdata[2*COORD_BITS-1:COORD_BITS];
            got_rgb = m_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS];
            if (pending_writes.size() == 0) begin
                err_count++;
                $display("%0t: unexpected pixel write at (%0d, %0d)", $time, got_x, got_y);
            end else begin
                want = pending_writes.pop_front();
                pixels_checked++;
                if (got_x !== want.x)
                    mismatch("pixel_x", want.x, got_x);
                if (got_y !== want.y)
                    mismatch("pixel_y", want.y, got_y);
                if (got_rgb !== want.rgb)
                    mismatch("pixel_color", want.rgb, got_rgb);
                if (m_tuser !== want.we)
                    mismatch("write_enable", want.we, m_tuser);
                if (m_tlast !== want.last)
                    mismatch("last", want.last, m_tlast);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Random line generation.
    // ---------------------------------------------------------------------
    function automatic int clamp_coord(input int v);
        if (v < -4096)
            return -4096;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // Start points cluster around the image edges, where clipping flips.
    function automatic int coord_near(input int dim);
        coord_t c;
        int r;
        r = $urandom_range(0, 2);
        c = $urandom;
        if (r == 0)
            return int'($urandom_range(0, 20)) - 10;
        if (r == 1)
            return clamp_coord(dim + int'($urandom_range(0, 20)) - 10);
        return c;
    endfunction

    // Mostly whole short lines, some abandoned ones, long lines cut short,
    // and stray advances.
    task automatic run_lines(input int n);
        int goal, mode, steps, x0, y0, x1, y1, d;
        goal = items_sent + n;
        while (items_sent < goal) begin
            mode = $urandom_range(0, 99);
            if (mode < 75) begin
                x0 = coord_near(int'(img_w));
                y0 = coord_near(int'(img_h));
                d = $urandom_range(0, 24);
                x1 = clamp_coord(x0 + d - 12);
                d = $urandom_range(0, 24);
                y1 = clamp_coord(y0 + d - 12);
                send_beat(KIND_BEGIN, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1),
                          COLOR_BITS'($urandom));
                // now and then replace the line before it ends
                steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 64;
                while (line_live && steps > 0) begin
                    send_advance();
                    steps--;
                end
                if ($urandom_range(0, 4) == 0)
                    send_advance();
            end else if (mode < 90) begin
                send_beat(KIND_BEGIN, coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), COLOR_BITS'($urandom));
                repeat ($urandom_range(1, 8)) send_advance();
            end else begin
                send_advance();
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset values, then both registers at their extremes with read-back.
    task automatic test_register_access();
        reg_check(REG_IMAGE_WIDTH);
        reg_check(REG_IMAGE_HEIGHT);
        set_image_size(0, 8191);
        set_image_size(8191, 0);
        set_image_size(1, 4096);
        set_image_size(4096, 1);
        set_image_size(640, 480);
    endtask

    // Short hand-picked lines at the default 640 x 480 image.
    task automatic test_directed_lines();
        // advance with nothing live: no write
        send_advance();
        // zero-length line stays idle
        send_beat(KIND_BEGIN, 7, 7, 7, 7, 24'hA5A5A5);
        send_advance();
        // full-range diagonals, replaced mid-line
        send_beat(KIND_BEGIN, -4096, -4096, 4095, 4095, 24'hFFFFFF);
        send_advance();
        send_advance();
        send_beat(KIND_BEGIN, 4095, 4095, -4096, -4096, 24'h000000);
        send_advance();
        send_advance();
        // a whole line to its last pixel, then one advance past the end
        send_beat(KIND_BEGIN, 0, 0, 2, 1, 24'h123456);
        while (line_live)
            send_advance();
        send_advance();
        // run across the right edge of the image
        send_beat(KIND_BEGIN, 639, 479, 641, 479, 24'h00FF00);
        send_advance();
        send_advance();
        // vertical and horizontal lines stepping downward
        send_beat(KIND_BEGIN, 0, 2, 0, 0, 24'h0000FF);
        send_advance();
        send_advance();
        send_beat(KIND_BEGIN, 2, 0, 0, 0, 24'hFF0000);
        send_advance();
        send_advance();
        wait_idle();
    endtask

    // Clipping at zero, tiny, large and odd image sizes.
    task automatic test_clipping_sizes();
        int widths[7]  = '{0, 1, 4096, 8191, 1, 4095, 640};
        int heights[7] = '{0, 1, 4096, 8191, 4096, 3, 480};
        foreach (widths[i]) begin
            set_image_size(DIM_BITS'(widths[i]), DIM_BITS'(heights[i]));
            run_lines(100);
        end
    endtask

    // Hold the output for a long stretch while advances keep coming, so the
    // block fills and throttles its input; then pause until all writes drain.
    task automatic test_output_stall();
        wait_idle();
        quiet = 1'b1;
        rx_hold_cycles = 300;
        send_beat(KIND_BEGIN, -4096, 3, 4095, 40, 24'h5A5A5A);
        repeat (120) send_advance();
        quiet = 1'b0;
        wait_idle();
    endtask

    // Random image sizes, alternating busy stretches with idle-free ones.
    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            set_image_size(DIM_BITS'($urandom_range(1, 4096)),
                           DIM_BITS'($urandom_range(1, 4096)));
            quiet = p[0];
            run_lines(120);
        end
        quiet = 1'b0;
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_BEGIN;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        img_w     = IMAGE_WIDTH_RESET;
        img_h     = IMAGE_HEIGHT_RESET;
        pen_x     = '0;
        pen_y     = '0;
        line_x0   = '0;
        line_y0   = '0;
        line_x1   = '0;
        line_y1   = '0;
        line_rgb  = '0;
        line_live = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_directed_lines();
        test_clipping_sizes();
        test_output_stall();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge aclk);
        if (pending_writes.size() != 0) begin
            err_count++;
            $display("%0t: %0d pixel writes never arrived", $time, pending_writes.size());
        end
        $display("Covered %0d beats over %0d lines and %0d image sizes; %0d pixel writes checked,",
                 items_sent, lines_begun, sizes_used, pixels_checked);
        $display("with random idles on both sides and one long output stall.");
        if (err_count == 0)
            $display("line_rasterizer_test: clean");
        else
            $display("line_rasterizer_test: errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lr_pkg.sv
hw/rtl/lr_regs.sv
hw/rtl/lr_core.sv
hw/rtl/lr_out.sv
hw/rtl/line_rasterizer.sv
sim/line_rasterizer_test.sv
